>>> src/mbp_pkg.sv
// ----------------------------------------------------------------------------
// mbp_pkg
// Shared types and constants for the MSB-first bit packer.
// ----------------------------------------------------------------------------
package mbp_pkg;

  // Default packing buffer size in bits (16..64)
  localparam int BUFFER_BITS_DEF = 64;

  // Widths of the packed-word path
  localparam int WORD_BITS = 64;
  localparam int BYTE_BITS = 8;
  localparam int BYTE_SH   = 3;
  localparam int MAX_BYTES = WORD_BITS / BYTE_BITS;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);

  // Depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // One job: up to eight bytes, left aligned, plus byte count and pad count
  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic [CNT_W-1:0]     nbytes;
    logic [2:0]           pad;
  } job_t;

endpackage

>>> src/mbp_front.sv
// ----------------------------------------------------------------------------
// mbp_front
// Accepts write and flush items, updates the bit buffer and hands every
// run of finished bytes to the job queue as one left-aligned word.
// ----------------------------------------------------------------------------
module mbp_front #(
  parameter int BUFFER_BITS = mbp_pkg::BUFFER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [mbp_pkg::WORD_BITS-1:0] in_field_value,
  input  logic [6:0]                    in_field_length,
  input  logic                          q_full,
  output logic                          q_push,
  output mbp_pkg::job_t                 q_job
);
  import mbp_pkg::*;

  // Usable buffer size: largest of 64, 32 or 16 not above BUFFER_BITS
  localparam int EFF = (BUFFER_BITS >= 64) ? 64 : ((BUFFER_BITS >= 32) ? 32 : 16);
  localparam int HW  = $clog2(EFF);
  localparam int CW  = EFF + WORD_BITS;
  localparam int TW  = $clog2(CW);
  localparam int SW  = $clog2(CW + 1);

  logic [EFF-1:0]       acc_r, acc_nxt;
  logic [HW-1:0]        held_r, held_nxt;

  logic                 accept;
  logic [6:0]           len_cl;
  logic [2:0]           pad;
  logic [6:0]           add_len;
  logic [WORD_BITS-1:0] lmask;
  logic [WORD_BITS-1:0] val_m;
  logic [CW-1:0]        comb_w;
  logic [CW-1:0]        left_w;
  logic [TW-1:0]        tot;
  logic [TW-1:0]        emit;
  logic [TW-1:0]        rem;
  logic [CNT_W-1:0]     nbytes;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Length clamp, value mask and flush pad count
  always_comb begin
    len_cl  = (in_field_length > 7'd64) ? 7'd64 : in_field_length;
    lmask   = (len_cl >= 7'd64) ? '1 : ((64'd1 << len_cl[5:0]) - 64'd1);
    pad     = 3'(3'd0 - held_r[2:0]);
    add_len = (in_operation == OP_FLUSH) ? {4'd0, pad} : len_cl;
    val_m   = (in_operation == OP_FLUSH) ? '0 : (in_field_value & lmask);
  end

  // Stream of held bits followed by new bits; bits above tot are don't-care
  always_comb begin
    comb_w = (CW'(acc_r) << add_len) | CW'(val_m);
    tot    = TW'(held_r) + TW'(add_len);
    // writes release whole buffers, a flush releases everything it holds
    emit   = (in_operation == OP_FLUSH) ? tot : {tot[TW-1:HW], {HW{1'b0}}};
    rem    = tot - emit;
    left_w = comb_w << (SW'(CW) - SW'(tot));
    nbytes = CNT_W'(emit >> BYTE_SH);
  end

  // Job to the queue
  always_comb begin
    q_job.word   = left_w[CW-1 -: WORD_BITS];
    q_job.nbytes = nbytes;
    q_job.pad    = (in_operation == OP_FLUSH) ? pad : 3'd0;
    q_push       = accept && (nbytes != '0);
  end

  // Buffer state update
  always_comb begin
    acc_nxt  = acc_r;
    held_nxt = held_r;
    if (accept) begin
      acc_nxt  = comb_w[EFF-1:0];
      held_nxt = (in_operation == OP_FLUSH) ? '0 : rem[HW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      held_r <= '0;
    end else begin
      acc_r  <= acc_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

>>> src/mbp_queue.sv
// ----------------------------------------------------------------------------
// mbp_queue
// Short first-in first-out queue of jobs between front and back.
// ----------------------------------------------------------------------------
module mbp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mbp_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output mbp_pkg::job_t head_job
);
  import mbp_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t          entry_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full       = (count_r == CW'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = entry_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> src/mbp_back.sv
// ----------------------------------------------------------------------------
// mbp_back
// Takes jobs from the queue and sends their bytes one at a time
// through an output register, most significant byte first.
// ----------------------------------------------------------------------------
module mbp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  mbp_pkg::job_t q_job,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          out_last_of_run,
  output logic [2:0]    out_pad_bits
);
  import mbp_pkg::*;

  logic                       busy_r, busy_nxt;
  logic [WORD_BITS-1:0]       word_r, word_nxt;
  logic [CNT_W-1:0]           left_r, left_nxt;
  logic [2:0]                 pad_r, pad_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [BYTE_BITS-1:0]       out_byte_r, out_byte_nxt;
  logic                       out_last_r, out_last_nxt;
  logic [2:0]                 out_pad_r, out_pad_nxt;

  logic                       out_free;
  logic                       emit;
  logic                       done;

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = busy_r && out_free;
  assign done     = emit && (left_r == CNT_W'(1));
  // next job loads as the current one sends its last byte
  assign q_pop    = q_valid && (!busy_r || done);

  always_comb begin
    busy_nxt      = busy_r && !done;
    word_nxt      = word_r;
    left_nxt      = left_r;
    pad_nxt       = pad_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_pad_nxt   = out_pad_r;

    if (out_free) begin
      out_valid_nxt = 1'b0;
    end
    // send the top byte and shift the rest up
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = word_r[WORD_BITS-1 -: BYTE_BITS];
      out_last_nxt  = (left_r == CNT_W'(1));
      out_pad_nxt   = pad_r;
      word_nxt      = word_r << BYTE_BITS;
      left_nxt      = left_r - 1'b1;
    end
    if (q_pop) begin
      busy_nxt = 1'b1;
      word_nxt = q_job.word;
      left_nxt = q_job.nbytes;
      pad_nxt  = q_job.pad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    word_r     <= word_nxt;
    left_r     <= left_nxt;
    pad_r      <= pad_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_pad_r  <= out_pad_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;
  assign out_pad_bits    = out_pad_r;

endmodule

>>> src/msb_first_bit_packer.sv
// ----------------------------------------------------------------------------
// msb_first_bit_packer
// Packs variable-length fields MSB first and releases them as bytes.
// ----------------------------------------------------------------------------
// A write appends the low field_length bits (0..64, larger values count as
// 64) of field_value; whenever the buffer fills, its bytes leave in
// big-endian order. A flush pads to a byte boundary and drains the buffer,
// each of its bytes carrying the pad count. The front end takes one item per
// cycle while its two-entry job queue has room; the output port carries one
// byte per cycle while out_stall is low. An item releases 0..8 bytes, and a
// stream of full 64-bit writes leaves no gap between the bytes of
// consecutive items.
module msb_first_bit_packer #(
  parameter int BUFFER_BITS = mbp_pkg::BUFFER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [mbp_pkg::WORD_BITS-1:0] in_field_value,
  input  logic [6:0]                    in_field_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_byte,
  output logic                          out_last_of_run,
  output logic [2:0]                    out_pad_bits
);
  import mbp_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  job_t push_job;
  job_t head_job;

  // Front: item intake and bit buffer
  mbp_front #(
    .BUFFER_BITS (BUFFER_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_field_value  (in_field_value),
    .in_field_length (in_field_length),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_job           (push_job)
  );

  // Job queue
  mbp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  // Back: byte serialiser
  mbp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_job           (head_job),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_pad_bits    (out_pad_bits)
  );

  // No job may be pushed into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job pushed into full queue");

  // Every queued job carries between one and eight bytes
  a_job_size: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (push_job.nbytes != '0 && push_job.nbytes <= CNT_W'(MAX_BYTES)))
    else $error("job byte count out of range");

  // The back end only pops a queue that holds a job
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

>>> verif/mbp_byte_checker.sv
// ----------------------------------------------------------------------------
// mbp_byte_checker
// Watches both channels of the bit packer and checks every byte it emits.
// Each accepted input word is run through a packing model of its own, which
// queues the bytes that word should release. Each accepted output byte is
// compared, field by field, with the oldest queued byte.
// ----------------------------------------------------------------------------
module mbp_byte_checker #(
  parameter int BUFFER_BITS = mbp_pkg::BUFFER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_operation,
  input  logic [mbp_pkg::WORD_BITS-1:0] in_field_value,
  input  logic [6:0]                    in_field_length,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [7:0]                    out_byte,
  input  logic                          out_last_of_run,
  input  logic [2:0]                    out_pad_bits,
  input  logic                          drain_check,
  output int                            failures,
  output int                            pending,
  output int                            words_in,
  output int                            flushes_in,
  output int                            bytes_checked
);
  import mbp_pkg::*;

  // Usable buffer size: largest of 64, 32 or 16 not above BUFFER_BITS
  localparam int EFF_BITS = (BUFFER_BITS >= 64) ? 64 : ((BUFFER_BITS >= 32) ? 32 : 16);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [2:0] pad;
  } packed_byte_t;

  // Model state
  logic [WORD_BITS-1:0] acc_bits;
  int                   held_bits;
  packed_byte_t         run_bytes [MAX_BYTES];
  int                   run_len;
  packed_byte_t         pending_bytes [$];
  bit                   drain_done;

  function automatic logic [WORD_BITS-1:0] field_mask(input int n);
    return (n >= WORD_BITS) ? ~'0 : ((64'd1 << n) - 64'd1);
  endfunction

  // Collect one byte of the current word's run (never more than eight)
  task automatic note_byte(input logic [7:0] data, input logic [2:0] pad);
    if (run_len < MAX_BYTES) begin
      run_bytes[run_len] = '{data: data, last: 1'b0, pad: pad};
      run_len++;
    end
  endtask

  // Shift len bits of v in, MSB first, releasing the buffer each time it fills
  task automatic append_field(input logic [WORD_BITS-1:0] v, input int len,
                              input logic [2:0] pad);
    int                   room;
    int                   take;
    logic [WORD_BITS-1:0] chunk;
    v = v & field_mask(len);
    while (len > 0) begin
      room  = EFF_BITS - held_bits;
      take  = (len < room) ? len : room;
      chunk = (v >> (len - take)) & field_mask(take);
      acc_bits  = (take >= WORD_BITS) ? chunk : ((acc_bits << take) | chunk);
      held_bits += take;
      len       -= take;
      if (held_bits >= EFF_BITS) begin
        for (int i = 0; i < EFF_BITS / BYTE_BITS; i++) begin
          chunk = acc_bits >> (EFF_BITS - BYTE_BITS - BYTE_BITS * i);
          note_byte(chunk[7:0], pad);
        end
        acc_bits  = '0;
        held_bits = 0;
      end
    end
  endtask

  // Work out the bytes released by one input word and queue them
  task automatic pack_word(input logic op, input logic [WORD_BITS-1:0] value,
                           input logic [6:0] len_raw);
    int                   len;
    int                   pad;
    logic [WORD_BITS-1:0] chunk;
    run_len = 0;
    if (op == OP_WRITE) begin
      len = int'(len_raw);
      if (len > WORD_BITS) len = WORD_BITS;
      append_field(value, len, 3'd0);
    end else if (held_bits > 0) begin
      pad = (BYTE_BITS - (held_bits % BYTE_BITS)) % BYTE_BITS;
      append_field('0, pad, 3'(pad));
      while (held_bits >= BYTE_BITS) begin
        held_bits -= BYTE_BITS;
        chunk = acc_bits >> held_bits;
        note_byte(chunk[7:0], 3'(pad));
      end
      acc_bits  = '0;
      held_bits = 0;
    end
    if (run_len > 0) run_bytes[run_len-1].last = 1'b1;
    for (int i = 0; i < run_len; i++) pending_bytes.push_back(run_bytes[i]);
  endtask

  task automatic log_failure(input string msg);
    failures++;
    if (failures <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Input side is handled first so a byte can never overtake its word
  always @(posedge clk) begin
    packed_byte_t want;
    if (!rst_n) begin
      acc_bits      = '0;
      held_bits     = 0;
      failures      = 0;
      words_in      = 0;
      flushes_in    = 0;
      bytes_checked = 0;
      drain_done    = 1'b0;
      pending_bytes.delete();
    end else begin
      if (in_valid && !in_stall) begin
        words_in++;
        if (in_operation == OP_FLUSH) flushes_in++;
        pack_word(in_operation, in_field_value, in_field_length);
      end
      if (out_valid && !out_stall) begin
        bytes_checked++;
        if (pending_bytes.size() == 0) begin
          log_failure($sformatf("unexpected byte %02h last %0d pad %0d",
                                out_byte, out_last_of_run, out_pad_bits));
        end else begin
          want = pending_bytes.pop_front();
          if (out_byte !== want.data || out_last_of_run !== want.last ||
              out_pad_bits !== want.pad) begin
            log_failure($sformatf("byte %02h/%02h last %0d/%0d pad %0d/%0d (exp/act)",
                                  want.data, out_byte, want.last, out_last_of_run,
                                  want.pad, out_pad_bits));
          end
        end
      end
      // Anything still queued at the end never came out
      if (drain_check && !drain_done) begin
        drain_done = 1'b1;
        if (pending_bytes.size() > 0) begin
          failures += pending_bytes.size();
          $display("%0d expected bytes never emitted", pending_bytes.size());
        end
      end
    end
    pending = pending_bytes.size();
  end

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the MSB-first bit packer.
// A directed set covers the length extremes, masking, full and overlong
// writes, empty flushes and flushes whose padding fills the buffer; a random
// set follows, with bursts of idling on both sides and a quiet tail.
// ----------------------------------------------------------------------------
module tb;
  import mbp_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_operation;
  logic [WORD_BITS-1:0] in_field_value;
  logic [6:0]           in_field_length;
  logic                 out_valid;
  logic                 out_stall;
  logic [7:0]           out_byte;
  logic                 out_last_of_run;
  logic [2:0]           out_pad_bits;
  logic                 drain_check;

  int failures;
  int pending;
  int words_in;
  int flushes_in;
  int bytes_checked;

  bit in_idling;
  bit out_idling;

  msb_first_bit_packer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_field_value  (in_field_value),
    .in_field_length (in_field_length),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_pad_bits    (out_pad_bits)
  );

  mbp_byte_checker u_byte_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_field_value  (in_field_value),
    .in_field_length (in_field_length),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_pad_bits    (out_pad_bits),
    .drain_check     (drain_check),
    .failures        (failures),
    .pending         (pending),
    .words_in        (words_in),
    .flushes_in      (flushes_in),
    .bytes_checked   (bytes_checked)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #2000000;
    $display("Run did not finish within its time limit");
    $display("RESULT: ERROR");
    $finish;
  end

  // Output stall: random bursts while enabled, otherwise open
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (out_idling && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12) - 1) @(negedge clk);
      end
    end
  end

  // Present one word and hold it until taken; called at a falling edge
  task automatic send_word(input logic op, input logic [WORD_BITS-1:0] value,
                           input logic [6:0] len);
    if (in_idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_field_value  <= value;
    in_field_length <= len;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_random_word();
    logic [WORD_BITS-1:0] value;
    int                   r;
    int                   len;
    value = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 15) begin
      send_word(OP_FLUSH, value, 7'($urandom_range(0, 127)));
    end else begin
      r = $urandom_range(0, 99);
      if (r < 4)       len = 0;
      else if (r < 10) len = $urandom_range(65, 127);
      else if (r < 25) len = 64;
      else if (r < 45) len = $urandom_range(1, 8);
      else             len = $urandom_range(1, 63);
      send_word(OP_WRITE, value, 7'(len));
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_operation    = OP_WRITE;
    in_field_value  = '0;
    in_field_length = '0;
    drain_check     = 1'b0;
    in_idling       = 1'b1;
    out_idling      = 1'b1;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, masking and the flush corner cases
    send_word(OP_FLUSH, '1, 7'd64);                   // flush of empty buffer
    send_word(OP_WRITE, '1, 7'd64);                   // full-width write, all ones
    send_word(OP_WRITE, '0, 7'd64);                   // full-width write, all zeros
    send_word(OP_WRITE, 64'h8000_0000_0000_0001, 7'd64);
    send_word(OP_WRITE, '1, 7'd1);                    // upper bits masked
    send_word(OP_FLUSH, '0, 7'd0);                    // seven pad bits
    send_word(OP_WRITE, 64'hDEAD_BEEF_0123_4567, 7'd0);  // zero length
    send_word(OP_WRITE, 64'h0123_4567_89AB_CDEF, 7'd127); // overlong length
    send_word(OP_WRITE, 64'hFEDC_BA98_7654_3210, 7'd65);
    send_word(OP_WRITE, 64'h5, 7'd3);
    send_word(OP_WRITE, 64'hA5A5_5A5A_C3C3_3C3C, 7'd64); // spans two buffers
    send_word(OP_FLUSH, '1, 7'd127);
    send_word(OP_WRITE, 64'hABCD, 7'd16);
    send_word(OP_FLUSH, '0, 7'd0);                    // already byte aligned
    send_word(OP_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 7'd60);
    send_word(OP_FLUSH, '0, 7'd0);                    // padding fills buffer
    send_word(OP_WRITE, 64'h7FFF_FFFF_FFFF_FFFF, 7'd63);
    send_word(OP_FLUSH, '0, 7'd0);
    send_word(OP_WRITE, 64'h00AB_CDEF_0123_4567, 7'd56);
    send_word(OP_FLUSH, '0, 7'd0);                    // seven bytes, no pad
    send_word(OP_FLUSH, '0, 7'd0);                    // empty again
    send_word(OP_WRITE, '1, 7'd63);
    send_word(OP_WRITE, '1, 7'd2);                    // one bit carries over
    send_word(OP_FLUSH, '0, 7'd0);

    // Random: segments with different idling, then a quiet tail
    for (int seg = 0; seg < 8; seg++) begin
      in_idling  = (seg % 4 == 0) || (seg % 4 == 1);
      out_idling = (seg % 4 == 0) || (seg % 4 == 2);
      repeat (20) send_random_word();
    end
    in_idling  = 1'b0;
    out_idling = 1'b0;
    repeat (40) send_random_word();
    send_word(OP_FLUSH, '0, 7'd0);
    in_valid <= 1'b0;

    // Drain, allow for stragglers, then settle
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    drain_check <= 1'b1;
    @(posedge clk);
    @(negedge clk);

    $display("Sent %0d words (%0d flushes); checked %0d output bytes.",
             words_in, flushes_in, bytes_checked);
    $display("Failures: %0d", failures);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
